// ----- design/glc_pkg.sv -----
// ----------------------------------------------------------------------------
// glc_pkg: shared types and constants of the generation checked LRU cache
// Request, status and scan codes, configuration layout and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package glc_pkg;

  localparam int unsigned KINDS     = 3;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned LOD_W     = 4;
  localparam int unsigned GEN_W     = 32;
  localparam int unsigned HANDLE_W  = 16;
  localparam int unsigned DIGEST_W  = 32;
  localparam int unsigned BYTE_W    = 32;
  localparam int unsigned LU_W      = 64;
  localparam int unsigned ELIM_W    = 7;
  localparam int unsigned STATUS_W  = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  localparam logic [ELIM_W-1:0] ENTRY_LIMIT_RST = 7'd64;
  localparam logic [BYTE_W-1:0] BYTE_LIMIT_RST  = 32'd1048576;

  localparam logic [CFG_IDX_W-1:0] CFG_MESH_ENTRY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MESH_BYTES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RENDER_ENTRY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RENDER_BYTES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLL_ENTRY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLL_BYTES   = 3'd5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_ERASE  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    RS_OK              = 4'd0,
    RS_BAD_CONFIG      = 4'd1,
    RS_BAD_INPUT       = 4'd2,
    RS_STALE           = 4'd3,
    RS_BAD_PAYLOAD     = 4'd4,
    RS_TOO_LARGE_MESH  = 4'd5,
    RS_TOO_LARGE_REND  = 4'd6,
    RS_TOO_LARGE_COLL  = 4'd7,
    RS_CONFLICT        = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    SC_NONE,
    SC_IDENT,
    SC_DROPKEY,
    SC_ERASE,
    SC_VICTIM,
    SC_MINUSE,
    SC_RENORM,
    SC_FREE
  } scan_e;

  typedef enum logic [4:0] {
    CS_IDLE,
    CS_DISPATCH,
    CS_IDENT,
    CS_IDENT_CHK,
    CS_DROPKEY,
    CS_NU,
    CS_MINUSE,
    CS_RNCALC,
    CS_RENORM,
    CS_APPLY,
    CS_INC,
    CS_TOUCH,
    CS_REFRESH,
    CS_FULLCHK,
    CS_FULLVICT,
    CS_FULLDROP,
    CS_FREE,
    CS_PLACE,
    CS_EVCHK,
    CS_EVVICT,
    CS_EVDROP,
    CS_ERASE,
    CS_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic [KINDS-1:0][ELIM_W-1:0] entry_limit;
    logic [KINDS-1:0][BYTE_W-1:0] byte_limit;
  } cfg_t;

  typedef struct packed {
    logic  capture;
    scan_e scan;
    logic  latch_pre;
    logic  set_bad_input;
    logic  set_conflict;
    logic  clear;
    logic  drop_sel;
    logic  use_zero;
    logic  calc_off;
    logic  apply_off;
    logic  use_inc;
    logic  touch;
    logic  refresh;
    logic  place;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic kind_bad;
    logic pre_ok;
    logic scan_done;
    logic hit;
    logic digest_eq;
    logic use_max;
    logic sel;
    logic full;
    logic over;
    logic out_free;
  } sts_t;

endpackage

// ----- design/generation_checked_lru_cache.sv -----
// ----------------------------------------------------------------------------
// generation_checked_lru_cache: three-kind LRU resource cache
// Keyed by chunk coordinates, detail level and generation, with per-kind
// entry and byte budgets and least-recently-used eviction.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: in_valid_i / in_stall_o with the request fields. A
//    request is taken when valid is high and stall is low; stall is high
//    while a request is in progress.
//  - Result channel: out_valid_o / out_stall_i, one result per request held
//    in an output register, so the next request can start while a result
//    waits to be taken. A stalled result holds its value.
//  - Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and
//    cfg_data_i; ready is always high. Write only while the cache is idle.
//  - Scans: every table scan walks the 3*ENTRIES_PER_KIND slots of the
//    slot memory at one slot per cycle (one read port). A use-counter wrap
//    adds a minimum-use scan and, when entries are resident, a renormalizing
//    scan.
//  - Reset clears all valid bits, counters and the use counter at once and
//    loads the default limits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module generation_checked_lru_cache #(
  parameter int unsigned ENTRIES_PER_KIND  = 64,
  parameter int unsigned MIN_PAYLOAD_BYTES = 64,
  parameter int unsigned COORD_BITS        = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [glc_pkg::REQ_W-1:0]         req_type_i,
  input  logic [glc_pkg::KIND_W-1:0]        resource_kind_i,
  input  logic signed [COORD_BITS-1:0]      chunk_x_i,
  input  logic signed [COORD_BITS-1:0]      chunk_y_i,
  input  logic signed [COORD_BITS-1:0]      chunk_z_i,
  input  logic [glc_pkg::LOD_W-1:0]         detail_level_i,
  input  logic [glc_pkg::GEN_W-1:0]         item_generation_i,
  input  logic [glc_pkg::GEN_W-1:0]         current_generation_i,
  input  logic [glc_pkg::HANDLE_W-1:0]      payload_handle_i,
  input  logic [glc_pkg::BYTE_W-1:0]        payload_bytes_i,
  input  logic                              payload_ok_i,
  input  logic [glc_pkg::DIGEST_W-1:0]      payload_digest_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [glc_pkg::STATUS_W-1:0]      status_o,
  output logic                              hit_o,
  output logic [glc_pkg::HANDLE_W-1:0]      found_handle_o,
  output logic [$clog2(3*ENTRIES_PER_KIND+1)-1:0] erased_count_o,
  output logic [$clog2(ENTRIES_PER_KIND+1)-1:0]   kind_entry_count_o,
  output logic [glc_pkg::BYTE_W-1:0]        kind_resident_bytes_o,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [glc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [glc_pkg::CFG_DAT_W-1:0]     cfg_data_i
);
  import glc_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Limit registers; a write never evicts, the next insert into the kind does.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KINDS; k++) begin
        cfg_q.entry_limit[k] <= ENTRY_LIMIT_RST;
        cfg_q.byte_limit[k]  <= BYTE_LIMIT_RST;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MESH_ENTRY:   cfg_q.entry_limit[0] <= cfg_data_i[ELIM_W-1:0];
        CFG_MESH_BYTES:   cfg_q.byte_limit[0]  <= cfg_data_i[BYTE_W-1:0];
        CFG_RENDER_ENTRY: cfg_q.entry_limit[1] <= cfg_data_i[ELIM_W-1:0];
        CFG_RENDER_BYTES: cfg_q.byte_limit[1]  <= cfg_data_i[BYTE_W-1:0];
        CFG_COLL_ENTRY:   cfg_q.entry_limit[2] <= cfg_data_i[ELIM_W-1:0];
        CFG_COLL_BYTES:   cfg_q.byte_limit[2]  <= cfg_data_i[BYTE_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Sequencer: accept, dispatch scans, load the result.
  glc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Slot table, occupancy and output register.
  glc_datapath #(
    .ENTRIES_PER_KIND  (ENTRIES_PER_KIND),
    .MIN_PAYLOAD_BYTES (MIN_PAYLOAD_BYTES),
    .COORD_BITS        (COORD_BITS)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg_q),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .req_type_i            (req_type_i),
    .resource_kind_i       (resource_kind_i),
    .chunk_x_i             (chunk_x_i),
    .chunk_y_i             (chunk_y_i),
    .chunk_z_i             (chunk_z_i),
    .detail_level_i        (detail_level_i),
    .item_generation_i     (item_generation_i),
    .current_generation_i  (current_generation_i),
    .payload_handle_i      (payload_handle_i),
    .payload_bytes_i       (payload_bytes_i),
    .payload_ok_i          (payload_ok_i),
    .payload_digest_i      (payload_digest_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .status_o              (status_o),
    .hit_o                 (hit_o),
    .found_handle_o        (found_handle_o),
    .erased_count_o        (erased_count_o),
    .kind_entry_count_o    (kind_entry_count_o),
    .kind_resident_bytes_o (kind_resident_bytes_o)
  );

endmodule

// ----- design/glc_ram.sv -----
// ----------------------------------------------------------------------------
// glc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module glc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/glc_ctrl.sv -----
// ----------------------------------------------------------------------------
// glc_ctrl: request sequencer
// Walks each request through its table scans and single-cycle updates.
// ----------------------------------------------------------------------------
module glc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  glc_pkg::sts_t sts_i,
  output glc_pkg::cmd_t cmd_o
);
  import glc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.scan = SC_NONE;
    in_stall_o = (state_q != CS_IDLE);
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CS_DISPATCH;
        end
      end
      CS_DISPATCH: begin
        case (sts_i.req)
          REQ_INSERT: begin
            cmd_o.latch_pre = 1'b1;
            state_d = sts_i.pre_ok ? CS_IDENT : CS_RESULT;
          end
          REQ_LOOKUP: begin
            if (sts_i.kind_bad) begin
              cmd_o.set_bad_input = 1'b1;
              state_d = CS_RESULT;
            end else begin
              state_d = CS_IDENT;
            end
          end
          REQ_ERASE: state_d = CS_ERASE;
          REQ_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = CS_RESULT;
          end
          default: state_d = CS_RESULT;
        endcase
      end
      CS_IDENT: begin
        cmd_o.scan = SC_IDENT;
        if (sts_i.scan_done) state_d = CS_IDENT_CHK;
      end
      CS_IDENT_CHK: begin
        if (sts_i.req == REQ_LOOKUP) begin
          state_d = sts_i.hit ? CS_NU : CS_RESULT;
        end else if (sts_i.hit) begin
          if (sts_i.digest_eq) begin
            state_d = CS_NU;
          end else begin
            cmd_o.set_conflict = 1'b1;
            state_d = CS_RESULT;
          end
        end else begin
          state_d = CS_DROPKEY;
        end
      end
      CS_DROPKEY: begin
        cmd_o.scan = SC_DROPKEY;
        if (sts_i.scan_done) state_d = CS_NU;
      end
      CS_NU: state_d = sts_i.use_max ? CS_MINUSE : CS_INC;
      CS_MINUSE: begin
        cmd_o.scan = SC_MINUSE;
        if (sts_i.scan_done) state_d = CS_RNCALC;
      end
      CS_RNCALC: begin
        if (sts_i.sel) begin
          cmd_o.calc_off = 1'b1;
          state_d = CS_RENORM;
        end else begin
          cmd_o.use_zero = 1'b1;
          state_d = CS_INC;
        end
      end
      CS_RENORM: begin
        cmd_o.scan = SC_RENORM;
        if (sts_i.scan_done) state_d = CS_APPLY;
      end
      CS_APPLY: begin
        cmd_o.apply_off = 1'b1;
        state_d = CS_INC;
      end
      CS_INC: begin
        cmd_o.use_inc = 1'b1;
        if (sts_i.req == REQ_LOOKUP) begin
          state_d = CS_TOUCH;
        end else if (sts_i.hit) begin
          state_d = CS_REFRESH;
        end else begin
          state_d = CS_FULLCHK;
        end
      end
      CS_TOUCH: begin
        cmd_o.touch = 1'b1;
        state_d = CS_RESULT;
      end
      CS_REFRESH: begin
        cmd_o.refresh = 1'b1;
        state_d = CS_EVCHK;
      end
      CS_FULLCHK: state_d = sts_i.full ? CS_FULLVICT : CS_FREE;
      CS_FULLVICT: begin
        cmd_o.scan = SC_VICTIM;
        if (sts_i.scan_done) state_d = CS_FULLDROP;
      end
      CS_FULLDROP: begin
        cmd_o.drop_sel = sts_i.sel;
        state_d = CS_FREE;
      end
      CS_FREE: begin
        cmd_o.scan = SC_FREE;
        if (sts_i.scan_done) state_d = CS_PLACE;
      end
      CS_PLACE: begin
        if (sts_i.sel) begin
          cmd_o.place = 1'b1;
          state_d = CS_EVCHK;
        end else begin
          state_d = CS_RESULT;
        end
      end
      CS_EVCHK: state_d = sts_i.over ? CS_EVVICT : CS_RESULT;
      CS_EVVICT: begin
        cmd_o.scan = SC_VICTIM;
        if (sts_i.scan_done) state_d = CS_EVDROP;
      end
      CS_EVDROP: begin
        if (sts_i.sel) begin
          cmd_o.drop_sel = 1'b1;
          state_d = CS_EVCHK;
        end else begin
          state_d = CS_RESULT;
        end
      end
      CS_ERASE: begin
        cmd_o.scan = SC_ERASE;
        if (sts_i.scan_done) state_d = CS_RESULT;
      end
      CS_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

endmodule

// ----- design/glc_datapath.sv -----
// ----------------------------------------------------------------------------
// glc_datapath: slot table, occupancy counters and result register
// Scans the slot memory one entry per cycle under controller command.
// ----------------------------------------------------------------------------
module glc_datapath #(
  parameter int unsigned ENTRIES_PER_KIND  = 64,
  parameter int unsigned MIN_PAYLOAD_BYTES = 64,
  parameter int unsigned COORD_BITS        = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  glc_pkg::cfg_t                     cfg_i,
  input  glc_pkg::cmd_t                     cmd_i,
  output glc_pkg::sts_t                     sts_o,
  input  logic [glc_pkg::REQ_W-1:0]         req_type_i,
  input  logic [glc_pkg::KIND_W-1:0]        resource_kind_i,
  input  logic signed [COORD_BITS-1:0]      chunk_x_i,
  input  logic signed [COORD_BITS-1:0]      chunk_y_i,
  input  logic signed [COORD_BITS-1:0]      chunk_z_i,
  input  logic [glc_pkg::LOD_W-1:0]         detail_level_i,
  input  logic [glc_pkg::GEN_W-1:0]         item_generation_i,
  input  logic [glc_pkg::GEN_W-1:0]         current_generation_i,
  input  logic [glc_pkg::HANDLE_W-1:0]      payload_handle_i,
  input  logic [glc_pkg::BYTE_W-1:0]        payload_bytes_i,
  input  logic                              payload_ok_i,
  input  logic [glc_pkg::DIGEST_W-1:0]      payload_digest_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [glc_pkg::STATUS_W-1:0]      status_o,
  output logic                              hit_o,
  output logic [glc_pkg::HANDLE_W-1:0]      found_handle_o,
  output logic [$clog2(3*ENTRIES_PER_KIND+1)-1:0] erased_count_o,
  output logic [$clog2(ENTRIES_PER_KIND+1)-1:0]   kind_entry_count_o,
  output logic [glc_pkg::BYTE_W-1:0]        kind_resident_bytes_o
);
  import glc_pkg::*;

  localparam int unsigned SLOTS     = KINDS * ENTRIES_PER_KIND;
  localparam int unsigned IDX_W     = $clog2(SLOTS);
  localparam int unsigned CIDX_W    = $clog2(SLOTS + 1);
  localparam int unsigned CNT_W     = $clog2(ENTRIES_PER_KIND + 1);
  localparam int unsigned ERASE_W   = $clog2(SLOTS + 1);
  localparam int unsigned KEY_W     = 3 * COORD_BITS + LOD_W;
  localparam int unsigned LU_LSB    = 0;
  localparam int unsigned BYTES_LSB = LU_LSB + LU_W;
  localparam int unsigned DIG_LSB   = BYTES_LSB + BYTE_W;
  localparam int unsigned HND_LSB   = DIG_LSB + DIGEST_W;
  localparam int unsigned GEN_LSB   = HND_LSB + HANDLE_W;
  localparam int unsigned KEY_LSB   = GEN_LSB + GEN_W;
  localparam int unsigned KIND_LSB  = KEY_LSB + KEY_W;
  localparam int unsigned WORD_W    = KIND_LSB + KIND_W;
  localparam int unsigned RANK_W    = LU_W + KEY_W + GEN_W;

  // Flip coordinate sign bits so an unsigned compare orders keys signed.
  localparam logic [KEY_W-1:0] KEY_FLIP =
    {{3{{1'b1, {(COORD_BITS-1){1'b0}}}}}, {LOD_W{1'b0}}};

  // Request capture
  req_e                  req_q;
  logic [KIND_W-1:0]     kind_q;
  logic [KEY_W-1:0]      key_q;
  logic [GEN_W-1:0]      gen_q;
  logic [GEN_W-1:0]      cur_q;
  logic [HANDLE_W-1:0]   handle_q;
  logic [BYTE_W-1:0]     nbytes_q;
  logic                  pok_q;
  logic [DIGEST_W-1:0]   digest_q;

  // Table state
  logic                  valid_q [SLOTS];
  logic                  valid_d [SLOTS];
  logic [CNT_W-1:0]      count_q [KINDS];
  logic [CNT_W-1:0]      count_d [KINDS];
  logic [BYTE_W:0]       bytes_q [KINDS];
  logic [BYTE_W:0]       bytes_d [KINDS];
  logic [LU_W-1:0]       use_q, use_d;
  logic [LU_W-1:0]       off_q;

  // Scan pipeline
  logic [CIDX_W-1:0]     idx_q, idx_d;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  issue;
  logic                  scan_done;
  logic [WORD_W-1:0]     rdata;

  // Scan results
  logic                  hit_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [WORD_W-1:0]     hit_word_q;
  logic                  sel_q;
  logic [IDX_W-1:0]      sel_idx_q;
  logic [WORD_W-1:0]     sel_word_q;
  logic [ERASE_W-1:0]    erased_q;
  status_e               status_q;

  // Result register
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic                  out_hit_q;
  logic [HANDLE_W-1:0]   out_handle_q;
  logic [ERASE_W-1:0]    out_erased_q;
  logic [CNT_W-1:0]      out_count_q;
  logic [BYTE_W-1:0]     out_bytes_q;

  // Element under inspection
  logic                  e_valid;
  logic [KIND_W-1:0]     e_kind;
  logic [KEY_W-1:0]      e_key;
  logic [GEN_W-1:0]      e_gen;
  logic [LU_W-1:0]       e_lu;
  logic [BYTE_W-1:0]     e_bytes;
  logic                  kind_m, key_m, gen_m;
  logic                  first;
  logic                  base_hit, base_sel;
  logic                  hit_set, sel_set, sel_upd;
  logic [RANK_W-1:0]     e_rank, sel_rank;

  logic                  scan_drop;
  logic                  drop_en;
  logic [IDX_W-1:0]      drop_idx;
  logic [KIND_W-1:0]     drop_kind;
  logic [BYTE_W-1:0]     drop_bytes;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [WORD_W-1:0]     wr_data;

  logic                  kind_bad;
  logic [KIND_W-1:0]     kidx;
  logic                  cfg_ok;
  status_e               pre_status;
  logic                  out_free;

  glc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (issue),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign kind_bad = (kind_q == KIND_NONE);
  assign kidx     = kind_bad ? '0 : kind_q;

  always_comb begin
    cfg_ok = 1'b1;
    for (int i = 0; i < KINDS; i++) begin
      if (cfg_i.entry_limit[i] == '0 ||
          32'(cfg_i.entry_limit[i]) > 32'(ENTRIES_PER_KIND) ||
          cfg_i.byte_limit[i] < 32'(MIN_PAYLOAD_BYTES)) begin
        cfg_ok = 1'b0;
      end
    end
  end

  always_comb begin
    if (!cfg_ok) begin
      pre_status = RS_BAD_CONFIG;
    end else if (handle_q == '0 || gen_q == '0 || cur_q == '0 || kind_bad) begin
      pre_status = RS_BAD_INPUT;
    end else if (gen_q != cur_q) begin
      pre_status = RS_STALE;
    end else if (!pok_q) begin
      pre_status = RS_BAD_PAYLOAD;
    end else if (nbytes_q > cfg_i.byte_limit[kidx]) begin
      case (kidx)
        2'd0:    pre_status = RS_TOO_LARGE_MESH;
        2'd1:    pre_status = RS_TOO_LARGE_REND;
        default: pre_status = RS_TOO_LARGE_COLL;
      endcase
    end else begin
      pre_status = RS_OK;
    end
  end

  // Scan address issue and read pipeline
  assign issue     = (cmd_i.scan != SC_NONE) && (idx_q < CIDX_W'(SLOTS));
  assign scan_done = rd_vld_q && (rd_idx_q == IDX_W'(SLOTS - 1));

  always_comb begin
    idx_d = idx_q;
    if (issue) idx_d = idx_q + 1'b1;
    if (scan_done) idx_d = '0;
  end

  assign e_valid = valid_q[rd_idx_q];
  assign e_kind  = rdata[KIND_LSB +: KIND_W];
  assign e_key   = rdata[KEY_LSB +: KEY_W];
  assign e_gen   = rdata[GEN_LSB +: GEN_W];
  assign e_lu    = rdata[LU_LSB +: LU_W];
  assign e_bytes = rdata[BYTES_LSB +: BYTE_W];
  assign kind_m  = (e_kind == kind_q);
  assign key_m   = (e_key == key_q);
  assign gen_m   = (e_gen == gen_q);
  assign first   = (rd_idx_q == '0);
  assign base_hit = hit_q && !first;
  assign base_sel = sel_q && !first;

  assign e_rank   = {e_lu, e_key ^ KEY_FLIP, e_gen};
  assign sel_rank = {sel_word_q[LU_LSB +: LU_W], sel_word_q[KEY_LSB +: KEY_W] ^ KEY_FLIP,
                     sel_word_q[GEN_LSB +: GEN_W]};

  assign hit_set = rd_vld_q && (cmd_i.scan == SC_IDENT) && e_valid && kind_m && key_m && gen_m;

  always_comb begin
    sel_set = 1'b0;
    sel_upd = 1'b0;
    if (rd_vld_q) begin
      case (cmd_i.scan)
        SC_VICTIM: begin
          sel_upd = 1'b1;
          sel_set = e_valid && kind_m && (!base_sel || e_rank < sel_rank);
        end
        SC_MINUSE: begin
          sel_upd = 1'b1;
          sel_set = e_valid && (!base_sel || e_lu < sel_word_q[LU_LSB +: LU_W]);
        end
        SC_FREE: begin
          sel_upd = 1'b1;
          sel_set = !e_valid && !base_sel;
        end
        default: begin
          sel_upd = 1'b0;
          sel_set = 1'b0;
        end
      endcase
    end
  end

  // Drop of a resident entry, from a scan or the selected victim
  assign scan_drop = rd_vld_q && e_valid && key_m &&
                     ((cmd_i.scan == SC_DROPKEY && kind_m) || cmd_i.scan == SC_ERASE);
  assign drop_en    = scan_drop || cmd_i.drop_sel;
  assign drop_idx   = cmd_i.drop_sel ? sel_idx_q : rd_idx_q;
  assign drop_kind  = cmd_i.drop_sel ? sel_word_q[KIND_LSB +: KIND_W] : e_kind;
  assign drop_bytes = cmd_i.drop_sel ? sel_word_q[BYTES_LSB +: BYTE_W] : e_bytes;

  // Slot memory writes
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx_q;
    wr_data = rdata;
    if (rd_vld_q && cmd_i.scan == SC_RENORM && e_valid) begin
      wr_en = 1'b1;
      wr_data[LU_LSB +: LU_W] = e_lu - off_q;
    end else if (cmd_i.touch) begin
      wr_en   = 1'b1;
      wr_addr = hit_idx_q;
      wr_data = hit_word_q;
      wr_data[LU_LSB +: LU_W] = use_q;
    end else if (cmd_i.refresh) begin
      wr_en   = 1'b1;
      wr_addr = hit_idx_q;
      wr_data = hit_word_q;
      wr_data[LU_LSB +: LU_W]       = use_q;
      wr_data[HND_LSB +: HANDLE_W]  = handle_q;
      wr_data[BYTES_LSB +: BYTE_W]  = nbytes_q;
    end else if (cmd_i.place) begin
      wr_en   = 1'b1;
      wr_addr = sel_idx_q;
      wr_data = {kind_q, key_q, gen_q, handle_q, digest_q, nbytes_q, use_q};
    end
  end

  // Valid bits and per-kind occupancy
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    bytes_d = bytes_q;
    if (cmd_i.clear) begin
      for (int s = 0; s < SLOTS; s++) valid_d[s] = 1'b0;
      for (int k = 0; k < KINDS; k++) begin
        count_d[k] = '0;
        bytes_d[k] = '0;
      end
    end else if (drop_en) begin
      valid_d[drop_idx]  = 1'b0;
      count_d[drop_kind] = count_q[drop_kind] - 1'b1;
      bytes_d[drop_kind] = bytes_q[drop_kind] - {1'b0, drop_bytes};
    end else if (cmd_i.refresh) begin
      bytes_d[kidx] = bytes_q[kidx] - {1'b0, hit_word_q[BYTES_LSB +: BYTE_W]}
                      + {1'b0, nbytes_q};
    end else if (cmd_i.place) begin
      valid_d[sel_idx_q] = 1'b1;
      count_d[kidx] = count_q[kidx] + 1'b1;
      bytes_d[kidx] = bytes_q[kidx] + {1'b0, nbytes_q};
    end
  end

  always_comb begin
    use_d = use_q;
    if (cmd_i.use_zero) begin
      use_d = '0;
    end else if (cmd_i.apply_off) begin
      use_d = use_q - off_q;
    end else if (cmd_i.use_inc) begin
      use_d = use_q + 1'b1;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS; s++) valid_q[s] <= 1'b0;
      for (int k = 0; k < KINDS; k++) begin
        count_q[k] <= '0;
        bytes_q[k] <= '0;
      end
      use_q       <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      count_q  <= count_d;
      bytes_q  <= bytes_d;
      use_q    <= use_d;
      idx_q    <= idx_d;
      rd_vld_q <= issue;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q[IDX_W-1:0];
    if (cmd_i.capture) begin
      req_q    <= req_e'(req_type_i);
      kind_q   <= resource_kind_i;
      key_q    <= {chunk_x_i, chunk_y_i, chunk_z_i, detail_level_i};
      gen_q    <= item_generation_i;
      cur_q    <= current_generation_i;
      handle_q <= payload_handle_i;
      nbytes_q <= payload_bytes_i;
      pok_q    <= payload_ok_i;
      digest_q <= payload_digest_i;
      hit_q    <= 1'b0;
      erased_q <= '0;
      status_q <= RS_OK;
    end else begin
      if (rd_vld_q && cmd_i.scan == SC_IDENT) begin
        hit_q <= base_hit || hit_set;
      end
      if (hit_set) begin
        hit_idx_q  <= rd_idx_q;
        hit_word_q <= rdata;
      end
      if (scan_drop && cmd_i.scan == SC_ERASE) begin
        erased_q <= erased_q + 1'b1;
      end
      if (cmd_i.latch_pre) begin
        status_q <= pre_status;
      end else if (cmd_i.set_bad_input) begin
        status_q <= RS_BAD_INPUT;
      end else if (cmd_i.set_conflict) begin
        status_q <= RS_CONFLICT;
      end
    end
    if (sel_upd) begin
      sel_q <= base_sel || sel_set;
    end
    if (sel_set) begin
      sel_idx_q  <= rd_idx_q;
      sel_word_q <= rdata;
    end
    if (cmd_i.calc_off) begin
      off_q <= (sel_word_q[LU_LSB +: LU_W] == '0) ? '0 : sel_word_q[LU_LSB +: LU_W] - 1'b1;
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_hit_q    <= (req_q == REQ_LOOKUP) && hit_q;
      out_handle_q <= ((req_q == REQ_LOOKUP) && hit_q) ? hit_word_q[HND_LSB +: HANDLE_W] : '0;
      out_erased_q <= erased_q;
      out_count_q  <= kind_bad ? '0 : count_q[kidx];
      out_bytes_q  <= kind_bad ? '0 : bytes_q[kidx][BYTE_W-1:0];
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.req       = req_q;
    sts_o.kind_bad  = kind_bad;
    sts_o.pre_ok    = (pre_status == RS_OK);
    sts_o.scan_done = scan_done;
    sts_o.hit       = hit_q;
    sts_o.digest_eq = (hit_word_q[DIG_LSB +: DIGEST_W] == digest_q);
    sts_o.use_max   = &use_q;
    sts_o.sel       = sel_q;
    sts_o.full      = (count_q[kidx] >= CNT_W'(ENTRIES_PER_KIND));
    sts_o.over      = (32'(count_q[kidx]) > 32'(cfg_i.entry_limit[kidx])) ||
                      (bytes_q[kidx] > {1'b0, cfg_i.byte_limit[kidx]});
    sts_o.out_free  = out_free;
  end

  assign out_valid_o           = out_valid_q;
  assign status_o              = out_status_q;
  assign hit_o                 = out_hit_q;
  assign found_handle_o        = out_handle_q;
  assign erased_count_o        = out_erased_q;
  assign kind_entry_count_o    = out_count_q;
  assign kind_resident_bytes_o = out_bytes_q;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over an unconsumed result");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (32'(rd_idx_q) < 32'(SLOTS)))
    else $error("scan read beyond slot table");

  a_empty_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q[0] == '0 || count_q[1] == '0 || count_q[2] == '0) |->
    ((count_q[0] != '0 || bytes_q[0] == '0) && (count_q[1] != '0 || bytes_q[1] == '0) &&
     (count_q[2] != '0 || bytes_q[2] == '0)))
    else $error("empty kind holds resident bytes");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(count_q[0]) <= 32'(ENTRIES_PER_KIND)) && (32'(count_q[1]) <= 32'(ENTRIES_PER_KIND)) &&
    (32'(count_q[2]) <= 32'(ENTRIES_PER_KIND)))
    else $error("kind entry count beyond region size");
`endif

endmodule

// ----- tb/generation_checked_lru_cache_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// generation_checked_lru_cache_tb: self-checking bench of the LRU cache
// Drives directed and random insert, lookup, erase and clear requests under
// several limit settings and handshake idling patterns. Every result is compared
// with a typed-in answer or with a cycle-free model of the slot table kept in the bench.
// ----------------------------------------------------------------------------
module generation_checked_lru_cache_tb;
  import glc_pkg::*;

  localparam int EPK       = 64;
  localparam int SLOT_CNT  = 3 * EPK;
  localparam int MIN_BYTES = 64;
  localparam int HANG_LIMIT = 200000;

  typedef struct packed {
    req_e               op;
    logic [1:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [3:0]         lod;
    logic [31:0]        gen;
    logic [31:0]        cur;
    logic [15:0]        handle;
    logic [31:0]        bytes;
    logic               ok;
    logic [31:0]        digest;
  } cache_req_t;

  typedef struct packed {
    status_e     st;
    logic        hit;
    logic [15:0] handle;
    logic [7:0]  erased;
    logic [6:0]  cnt;
    logic [31:0] bytes;
  } cache_rsp_t;

  typedef struct packed {
    cache_req_t rq;
    logic       known;
    cache_rsp_t rsp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  // request channel
  logic       in_valid;
  logic       in_stall_o;
  cache_req_t cur_req;
  logic       cur_known;
  cache_rsp_t cur_rsp;

  // result channel
  logic        out_valid_o;
  logic        out_stall;
  logic [3:0]  status_o;
  logic        hit_o;
  logic [15:0] found_handle_o;
  logic [7:0]  erased_count_o;
  logic [6:0]  kind_entry_count_o;
  logic [31:0] kind_resident_bytes_o;

  // configuration channel
  logic        cfg_valid;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int idle_mode;  // 0 none, 1 sender idles, 2 receiver stalls, 3 both rarely
  int err_cnt;
  int quiet_cycles;
  cache_rsp_t pending_rsp[$];
  stim_row_t  rows[$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  generation_checked_lru_cache dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall_o),
    .req_type_i            (cur_req.op),
    .resource_kind_i       (cur_req.kind),
    .chunk_x_i             (cur_req.x),
    .chunk_y_i             (cur_req.y),
    .chunk_z_i             (cur_req.z),
    .detail_level_i        (cur_req.lod),
    .item_generation_i     (cur_req.gen),
    .current_generation_i  (cur_req.cur),
    .payload_handle_i      (cur_req.handle),
    .payload_bytes_i       (cur_req.bytes),
    .payload_ok_i          (cur_req.ok),
    .payload_digest_i      (cur_req.digest),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall),
    .status_o              (status_o),
    .hit_o                 (hit_o),
    .found_handle_o        (found_handle_o),
    .erased_count_o        (erased_count_o),
    .kind_entry_count_o    (kind_entry_count_o),
    .kind_resident_bytes_o (kind_resident_bytes_o),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Slot table model: a mirror of the cache state, updated per request
  // --------------------------------------------------------------------------
  bit                 tbl_valid [SLOT_CNT];
  logic [1:0]         tbl_kind  [SLOT_CNT];
  logic signed [15:0] tbl_x     [SLOT_CNT];
  logic signed [15:0] tbl_y     [SLOT_CNT];
  logic signed [15:0] tbl_z     [SLOT_CNT];
  logic [3:0]         tbl_lod   [SLOT_CNT];
  logic [31:0]        tbl_gen   [SLOT_CNT];
  logic [15:0]        tbl_handle[SLOT_CNT];
  logic [31:0]        tbl_digest[SLOT_CNT];
  logic [31:0]        tbl_bytes [SLOT_CNT];
  logic [63:0]        tbl_use   [SLOT_CNT];
  logic [63:0]        use_stamp;
  logic [32:0]        kind_bytes[3];
  int                 kind_cnt  [3];
  logic [6:0]         lim_entries[3];
  logic [31:0]        lim_bytes [3];

  function automatic bit same_key(int s, cache_req_t r);
    return tbl_x[s] == r.x && tbl_y[s] == r.y && tbl_z[s] == r.z && tbl_lod[s] == r.lod;
  endfunction

  // signed key order of two slots: -1, 0 or 1
  function automatic int key_order(int a, int b);
    if (tbl_x[a] != tbl_x[b]) return tbl_x[a] < tbl_x[b] ? -1 : 1;
    if (tbl_y[a] != tbl_y[b]) return tbl_y[a] < tbl_y[b] ? -1 : 1;
    if (tbl_z[a] != tbl_z[b]) return tbl_z[a] < tbl_z[b] ? -1 : 1;
    if (tbl_lod[a] != tbl_lod[b]) return tbl_lod[a] < tbl_lod[b] ? -1 : 1;
    return 0;
  endfunction

  function automatic bit limits_sane();
    for (int k = 0; k < 3; k++) begin
      if (lim_entries[k] == 0 || lim_entries[k] > EPK) return 0;
      if (lim_bytes[k] < MIN_BYTES) return 0;
    end
    return 1;
  endfunction

  // advance the use stamp; at its ceiling shift all stamps so the oldest is 1
  function automatic logic [63:0] next_stamp();
    logic [63:0] lo;
    bit          any;
    if (use_stamp == '1) begin
      lo  = use_stamp;
      any = 0;
      for (int s = 0; s < SLOT_CNT; s++)
        if (tbl_valid[s]) begin
          any = 1;
          if (tbl_use[s] < lo) lo = tbl_use[s];
        end
      if (!any) use_stamp = '0;
      else begin
        if (lo != 0) lo = lo - 1;
        for (int s = 0; s < SLOT_CNT; s++) if (tbl_valid[s]) tbl_use[s] -= lo;
        use_stamp -= lo;
      end
    end
    use_stamp++;
    return use_stamp;
  endfunction

  function automatic void drop_entry(int s);
    kind_bytes[tbl_kind[s]] -= tbl_bytes[s];
    kind_cnt[tbl_kind[s]]--;
    tbl_valid[s] = 0;
  endfunction

  function automatic int find_entry(int k, cache_req_t r, logic [31:0] g);
    for (int s = 0; s < SLOT_CNT; s++)
      if (tbl_valid[s] && tbl_kind[s] == k && tbl_gen[s] == g && same_key(s, r)) return s;
    return -1;
  endfunction

  // least recently used entry of a kind; ties go to the lower key, then gen
  function automatic int oldest_entry(int k);
    int best;
    int c;
    best = -1;
    for (int s = 0; s < SLOT_CNT; s++) begin
      if (!tbl_valid[s] || tbl_kind[s] != k) continue;
      if (best < 0) begin
        best = s;
        continue;
      end
      if (tbl_use[s] != tbl_use[best]) begin
        if (tbl_use[s] < tbl_use[best]) best = s;
        continue;
      end
      c = key_order(s, best);
      if (c < 0 || (c == 0 && tbl_gen[s] < tbl_gen[best])) best = s;
    end
    return best;
  endfunction

  function automatic void trim_kind(int k);
    int v;
    while (kind_cnt[k] > lim_entries[k] || kind_bytes[k] > lim_bytes[k]) begin
      v = oldest_entry(k);
      if (v < 0) break;
      drop_entry(v);
    end
  endfunction

  function automatic status_e insert_entry(cache_req_t r);
    int          k;
    int          e;
    int          s;
    logic [63:0] stamp;
    k = r.kind;
    if (!limits_sane()) return RS_BAD_CONFIG;
    if (r.handle == 0 || r.gen == 0 || r.cur == 0 || r.kind == KIND_NONE) return RS_BAD_INPUT;
    if (r.gen != r.cur) return RS_STALE;
    if (!r.ok) return RS_BAD_PAYLOAD;
    if (r.bytes > lim_bytes[k]) begin
      case (k)
        0:       return RS_TOO_LARGE_MESH;
        1:       return RS_TOO_LARGE_REND;
        default: return RS_TOO_LARGE_COLL;
      endcase
    end
    e = find_entry(k, r, r.gen);
    if (e >= 0) begin
      // same identity: refresh on equal digest, otherwise a conflict
      if (tbl_digest[e] != r.digest) return RS_CONFLICT;
      kind_bytes[k] -= tbl_bytes[e];
      tbl_handle[e] = r.handle;
      tbl_bytes[e]  = r.bytes;
      tbl_use[e]    = next_stamp();
      kind_bytes[k] += r.bytes;
      trim_kind(k);
      return RS_OK;
    end
    // a new generation replaces every other one of the key in the kind
    for (s = 0; s < SLOT_CNT; s++)
      if (tbl_valid[s] && tbl_kind[s] == k && same_key(s, r)) drop_entry(s);
    stamp = next_stamp();
    if (kind_cnt[k] >= EPK) begin
      e = oldest_entry(k);
      if (e >= 0) drop_entry(e);
    end
    for (s = 0; s < SLOT_CNT; s++) if (!tbl_valid[s]) break;
    if (s >= SLOT_CNT) return RS_OK;
    tbl_valid[s]  = 1;
    tbl_kind[s]   = r.kind;
    tbl_x[s]      = r.x;
    tbl_y[s]      = r.y;
    tbl_z[s]      = r.z;
    tbl_lod[s]    = r.lod;
    tbl_gen[s]    = r.gen;
    tbl_handle[s] = r.handle;
    tbl_digest[s] = r.digest;
    tbl_bytes[s]  = r.bytes;
    tbl_use[s]    = stamp;
    kind_cnt[k]++;
    kind_bytes[k] += r.bytes;
    trim_kind(k);
    return RS_OK;
  endfunction

  function automatic cache_rsp_t apply_request(cache_req_t r);
    cache_rsp_t o;
    int         e;
    o = '0;
    o.st = RS_OK;
    case (r.op)
      REQ_INSERT: o.st = insert_entry(r);
      REQ_LOOKUP: begin
        if (r.kind == KIND_NONE) o.st = RS_BAD_INPUT;
        else begin
          e = find_entry(r.kind, r, r.gen);
          if (e >= 0) begin
            tbl_use[e] = next_stamp();
            o.hit      = 1'b1;
            o.handle   = tbl_handle[e];
          end
        end
      end
      REQ_ERASE: begin
        for (int s = 0; s < SLOT_CNT; s++)
          if (tbl_valid[s] && same_key(s, r)) begin
            drop_entry(s);
            o.erased++;
          end
      end
      default: begin
        // clear keeps the use stamp running
        for (int s = 0; s < SLOT_CNT; s++) tbl_valid[s] = 0;
        for (int k = 0; k < 3; k++) begin
          kind_cnt[k]   = 0;
          kind_bytes[k] = '0;
        end
      end
    endcase
    if (r.kind != KIND_NONE) begin
      o.cnt   = kind_cnt[r.kind][6:0];
      o.bytes = kind_bytes[r.kind][31:0];
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors: predict on request acceptance, compare on result acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cache_rsp_t p;
    if (rst_ni && in_valid && !in_stall_o) begin
      p = apply_request(cur_req);
      // typed-in rows still advance the model so later rows stay in step
      pending_rsp.push_back(cur_known ? cur_rsp : p);
    end
  end

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    cache_rsp_t w;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual status %0h",
                 $time, status_o);
        err_cnt++;
      end else begin
        w = pending_rsp.pop_front();
        cmp_field("status", w.st, status_o);
        cmp_field("hit", w.hit, hit_o);
        cmp_field("found_handle", w.handle, found_handle_o);
        cmp_field("erased_count", w.erased, erased_count_o);
        cmp_field("kind_entry_count", w.cnt, kind_entry_count_o);
        cmp_field("kind_resident_bytes", w.bytes, kind_resident_bytes_o);
      end
    end
  end

  // receiver stall pattern follows the current idle mode
  always @(posedge clk_i) begin
    case (idle_mode)
      2:       out_stall <= $urandom_range(99) < 77;
      3:       out_stall <= $urandom_range(99) < 7;
      default: out_stall <= 1'b0;
    endcase
  end

  // hang detection: count cycles in which no handshake completes
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic bit sender_idles();
    case (idle_mode)
      1:       return $urandom_range(99) < 77;
      3:       return $urandom_range(99) < 7;
      default: return 0;
    endcase
  endfunction

  // present one request and hold it until the cache takes it
  task automatic send_request(cache_req_t r, logic known, cache_rsp_t w);
    if (sender_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while (sender_idles()) @(posedge clk_i);
    end
    cur_req   <= r;
    cur_known <= known;
    cur_rsp   <= w;
    in_valid  <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // drop valid and wait until every outstanding result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx[0]) lim_bytes[idx >> 1] = val;
    else lim_entries[idx >> 1] = val[6:0];
  endtask

  function automatic cache_req_t mk_req(req_e op, logic [1:0] k, logic signed [15:0] x,
                                        logic signed [15:0] y, logic signed [15:0] z,
                                        logic [3:0] lod, logic [31:0] gen, logic [31:0] cur,
                                        logic [15:0] h, logic [31:0] b, logic ok,
                                        logic [31:0] d);
    cache_req_t r;
    r = '{op, k, x, y, z, lod, gen, cur, h, b, ok, d};
    return r;
  endfunction

  function automatic cache_rsp_t mk_rsp(status_e st, logic [6:0] cnt, logic [31:0] b);
    cache_rsp_t o;
    o = '{st, 1'b0, 16'h0, 8'h0, cnt, b};
    return o;
  endfunction

  function automatic logic signed [15:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $signed(16'($urandom_range(2))) - 16'sd1;
    if (r < 90) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    return 16'($urandom);
  endfunction

  // mostly well-formed requests over a small key and generation pool so that
  // hits, refreshes, conflicts and replacements are frequent; some pure noise
  function automatic cache_req_t random_request();
    cache_req_t r;
    int         pick;
    if ($urandom_range(99) < 10) begin
      r = '{req_e'($urandom_range(3)), 2'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 4'($urandom), $urandom, $urandom, 16'($urandom), $urandom,
            1'($urandom), $urandom};
      return r;
    end
    pick = $urandom_range(99);
    r.op = pick < 50 ? REQ_INSERT : pick < 85 ? REQ_LOOKUP : pick < 97 ? REQ_ERASE : REQ_CLEAR;
    r.kind   = $urandom_range(99) < 3 ? KIND_NONE : 2'($urandom_range(2));
    r.x      = pick_coord();
    r.y      = pick_coord();
    r.z      = pick_coord();
    r.lod    = $urandom_range(99) < 85 ? 4'($urandom_range(1)) : 4'($urandom);
    r.cur    = $urandom_range(99) < 90 ? 32'($urandom_range(1, 3)) : $urandom;
    r.gen    = $urandom_range(99) < 90 ? r.cur : 32'($urandom_range(4));
    r.handle = $urandom_range(99) < 95 ? 16'($urandom_range(1, 65535)) : 16'h0;
    r.ok     = $urandom_range(99) < 95;
    r.digest = $urandom_range(99) < 90 ? 32'($urandom_range(1)) : $urandom;
    pick = $urandom_range(99);
    r.bytes  = pick < 70 ? 32'($urandom_range(600)) :
               pick < 90 ? 32'($urandom_range(300000)) : $urandom;
    return r;
  endfunction

  // limit settings per random phase: entries/bytes for mesh, render, collision
  logic [31:0] limit_plan [6][6] = '{
    '{64, 1048576, 64, 1048576, 64, 1048576},
    '{4, 2000, 3, 1000, 2, 500},
    '{64, 32'hFFFF_FFFF, 1, 64, 64, 64},
    '{0, 1048576, 64, 1048576, 64, 1048576},        // zero entry limit: invalid
    '{64, 1048576, 127, 1048576, 64, 63},           // over range and too few bytes
    '{8, 4096, 64, 600000, 16, 300}
  };

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    cache_req_t base;
    cache_req_t r;
    cache_rsp_t none;
    none       = '0;
    idle_mode  = 0;
    err_cnt    = 0;
    quiet_cycles = 0;
    use_stamp  = '0;
    for (int s = 0; s < SLOT_CNT; s++) tbl_valid[s] = 0;
    for (int k = 0; k < 3; k++) begin
      kind_cnt[k]    = 0;
      kind_bytes[k]  = '0;
      lim_entries[k] = ENTRY_LIMIT_RST;
      lim_bytes[k]   = BYTE_LIMIT_RST;
    end
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    cur_req   <= '0;
    cur_known <= 1'b0;
    cur_rsp   <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: requests on the empty cache have fixed answers
    base = mk_req(REQ_INSERT, 2'd0, 16'sd0, 16'sd0, 16'sd0, 4'd0, 32'd1, 32'd1, 16'd7,
                  32'd100, 1'b1, 32'd5);
    r = base; r.op = REQ_LOOKUP;
    rows.push_back('{r, 1'b1, mk_rsp(RS_OK, 0, 0)});
    r = base; r.kind = KIND_NONE;
    rows.push_back('{r, 1'b1, mk_rsp(RS_BAD_INPUT, 0, 0)});
    r = base; r.handle = 16'h0;
    rows.push_back('{r, 1'b1, mk_rsp(RS_BAD_INPUT, 0, 0)});
    r = base; r.gen = 32'h0;
    rows.push_back('{r, 1'b1, mk_rsp(RS_BAD_INPUT, 0, 0)});
    r = base; r.cur = 32'h0;
    rows.push_back('{r, 1'b1, mk_rsp(RS_BAD_INPUT, 0, 0)});
    r = base; r.gen = 32'd2;
    rows.push_back('{r, 1'b1, mk_rsp(RS_STALE, 0, 0)});
    r = base; r.ok = 1'b0;
    rows.push_back('{r, 1'b1, mk_rsp(RS_BAD_PAYLOAD, 0, 0)});
    r = base; r.bytes = BYTE_LIMIT_RST + 1;
    rows.push_back('{r, 1'b1, mk_rsp(RS_TOO_LARGE_MESH, 0, 0)});
    r.kind = 2'd1;
    rows.push_back('{r, 1'b1, mk_rsp(RS_TOO_LARGE_REND, 0, 0)});
    r.kind = 2'd2;
    rows.push_back('{r, 1'b1, mk_rsp(RS_TOO_LARGE_COLL, 0, 0)});
    r = base; r.op = REQ_LOOKUP; r.kind = KIND_NONE;
    rows.push_back('{r, 1'b1, mk_rsp(RS_BAD_INPUT, 0, 0)});
    r = base; r.op = REQ_ERASE;
    rows.push_back('{r, 1'b1, mk_rsp(RS_OK, 0, 0)});
    // the remaining rows depend on the table contents
    r = mk_req(REQ_INSERT, 2'd0, 16'sh8000, 16'sh7FFF, 16'sd0, 4'd15, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 16'hFFFF, BYTE_LIMIT_RST, 1'b1, 32'hFFFF_FFFF);
    rows.push_back('{r, 1'b0, none});
    r.digest = 32'h0;                                    // identity conflict
    rows.push_back('{r, 1'b0, none});
    r.digest = 32'hFFFF_FFFF; r.handle = 16'd1; r.bytes = 32'd64;  // refresh
    rows.push_back('{r, 1'b0, none});
    r.op = REQ_LOOKUP;                                   // hit
    rows.push_back('{r, 1'b0, none});
    r.gen = 32'd9;                                       // wrong generation
    rows.push_back('{r, 1'b0, none});
    r.op = REQ_INSERT; r.kind = 2'd1; r.gen = 32'd1; r.cur = 32'd1; r.handle = 16'd2;
    rows.push_back('{r, 1'b0, none});
    r.gen = 32'd2; r.cur = 32'd2;                        // replaces generation 1
    rows.push_back('{r, 1'b0, none});
    r.kind = 2'd2; r.gen = 32'd5; r.cur = 32'd5;
    rows.push_back('{r, 1'b0, none});
    r.op = REQ_ERASE;                                    // key in all three kinds
    rows.push_back('{r, 1'b0, none});
    rows.push_back('{base, 1'b0, none});
    r = base; r.op = REQ_CLEAR;
    rows.push_back('{r, 1'b0, none});
    r = base; r.op = REQ_LOOKUP;
    rows.push_back('{r, 1'b0, none});
    foreach (rows[i]) send_request(rows[i].rq, rows[i].known, rows[i].rsp);

    // overfill the mesh region so the full-region replacement path runs
    for (int i = 0; i < 68; i++) begin
      r = base;
      r.x = 16'(i);
      r.handle = 16'(i + 1);
      send_request(r, 1'b0, none);
    end

    // random phases, each behind a fresh set of limits
    for (int p = 0; p < 6; p++) begin
      drain();
      for (int i = 0; i < 6; i++) write_limit(3'(i), limit_plan[p][i]);
      cfg_valid <= 1'b0;
      for (int n = 0; n < 200; n++) begin
        idle_mode = (n / 50 + p) % 4;
        send_request(random_request(), 1'b0, none);
      end
    end

    drain();
    idle_mode = 0;
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && pending_rsp.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
